@@ hdl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the heap queue controller, datapath and top.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   max_key;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_TOP,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_RIGHT
  } state_e;

  typedef enum logic [2:0] {
    RD_PARENT,
    RD_ROOT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_PARENT,
    POS_CAND
  } pos_sel_e;

  typedef struct packed {
    logic     ins_load;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     cap_top;
    logic     cap_mov;
    logic     cap_left;
    logic     use_right;
    logic     wr_en;
    logic     wr_mov;
    pos_sel_e pos_sel;
    logic     finish;
    status_e  res_status;
    logic     res_del;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic left_beyond;
    logic right_ok;
    logic rd_ge_mov;
    logic mov_ge_cand;
  } dp_stat_t;

endpackage

@@ hdl/bmhq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/bmhq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert sift-up and delete sift-down over the heap store.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bmhq_pkg::cmd_e    command_i,
  input  bmhq_pkg::dp_stat_t stat_i,
  output logic              busy_o,
  output bmhq_pkg::dp_cmd_t cmd_o
);
  import bmhq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_INSERT) begin
            if (stat_i.full) begin
              cmd_o.finish     = 1'b1;
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.ins_load = 1'b1;
              state_d        = S_UP_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.finish     = 1'b1;
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ROOT;
              state_d      = S_DN_TOP;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_root) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_mov = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.rd_ge_mov) begin
          cmd_o.wr_mov = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.pos_sel = POS_PARENT;
          state_d       = S_UP_RD;
        end
      end
      S_DN_TOP: begin
        cmd_o.cap_top = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_LAST;
        state_d       = S_DN_LAST;
      end
      S_DN_LAST: begin
        cmd_o.cap_mov = 1'b1;
        state_d       = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat_i.left_beyond) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_mov  = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.res_del = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_DN_LEFT;
        end
      end
      S_DN_LEFT, S_DN_RIGHT: begin
        if (state_q == S_DN_LEFT) begin
          cmd_o.cap_left = 1'b1;
        end else begin
          cmd_o.use_right = 1'b1;
        end
        if (state_q == S_DN_LEFT && stat_i.right_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_RIGHT;
          state_d      = S_DN_RIGHT;
        end else if (stat_i.mov_ge_cand) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_mov  = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.res_del = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.pos_sel = POS_CAND;
          state_d       = S_DN_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/bmhq_dpath.sv @@
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap store, entry count, slot pointers, key registers and result register.
// ----------------------------------------------------------------------------
module bmhq_dpath #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmhq_pkg::req_t     req_i,
  input  bmhq_pkg::dp_cmd_t  cmd_i,
  output bmhq_pkg::dp_stat_t stat_o,
  output logic               done_o,
  output bmhq_pkg::rsp_t     rsp_o
);
  import bmhq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       cidx_q;
  logic [KEY_BITS-1:0] mov_q, top_q, child_q;
  logic                done_q;
  rsp_t                rsp_q;

  logic [KEY_BITS-1:0] rd_data, cand, wr_data;
  logic [CW:0]         left_idx, right_idx, cnt_ext, rd_slot, rd_slot_m1, wr_slot_m1;
  logic [CW-1:0]       cand_idx;
  logic                take_right;

  assign cnt_ext   = {1'b0, cnt_q};
  assign left_idx  = {pos_q, 1'b0};
  assign right_idx = left_idx + (CW+1)'(1);

  assign take_right = cmd_i.use_right && (child_q < rd_data);

  always_comb begin
    if (!cmd_i.use_right) begin
      cand     = rd_data;
      cand_idx = left_idx[CW-1:0];
    end else if (take_right) begin
      cand     = rd_data;
      cand_idx = cidx_q + CW'(1);
    end else begin
      cand     = child_q;
      cand_idx = cidx_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PARENT: rd_slot = {2'b00, pos_q[CW-1:1]};
      RD_ROOT:   rd_slot = (CW+1)'(1);
      RD_LAST:   rd_slot = cnt_ext;
      RD_LEFT:   rd_slot = left_idx;
      RD_RIGHT:  rd_slot = right_idx;
      default:   rd_slot = (CW+1)'(1);
    endcase
  end

  assign rd_slot_m1 = rd_slot - (CW+1)'(1);
  assign wr_slot_m1 = {1'b0, pos_q} - (CW+1)'(1);
  assign wr_data    = cmd_i.wr_mov ? mov_q : cand;

  bmhq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_slot_m1[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_slot_m1[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.ins_load) begin
      cnt_d = cnt_q + CW'(1);
      pos_d = cnt_q + CW'(1);
    end else if (cmd_i.cap_mov) begin
      cnt_d = cnt_q - CW'(1);
      pos_d = CW'(1);
    end else begin
      case (cmd_i.pos_sel)
        POS_PARENT: pos_d = pos_q >> 1;
        POS_CAND:   pos_d = cand_idx;
        default:    pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.ins_load) begin
      mov_q <= KEY_BITS'(req_i.key);
    end else if (cmd_i.cap_mov) begin
      mov_q <= rd_data;
    end
    if (cmd_i.cap_top) begin
      top_q <= rd_data;
    end
    if (cmd_i.cap_left) begin
      child_q <= rd_data;
      cidx_q  <= left_idx[CW-1:0];
    end
    if (cmd_i.finish) begin
      rsp_q.max_key <= cmd_i.res_del ? KEY_W'(top_q) : '0;
      rsp_q.status  <= cmd_i.res_status;
      rsp_q.count   <= COUNT_W'(cnt_q);
    end
  end

  assign stat_o.full        = (cnt_q == CW'(DEPTH));
  assign stat_o.empty       = (cnt_q == '0);
  assign stat_o.pos_root    = (pos_q == CW'(1));
  assign stat_o.left_beyond = (left_idx > cnt_ext);
  assign stat_o.right_ok    = (right_idx <= cnt_ext);
  assign stat_o.rd_ge_mov   = (rd_data >= mov_q);
  assign stat_o.mov_ge_cand = (mov_q >= cand);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ hdl/binary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Binary max-heap priority queue: insert a key or remove the maximum.
// ----------------------------------------------------------------------------
// insert: per level climbed, the parent is read and then either moved down or
//   the key is written in its place; a key reaching the root is written there
// delete: setup reads the root and the last entry, then each level walked down
//   takes up to two reads and a write on the single-read-port heap RAM, then the
//   result is registered; full or empty rejects: result in the cycle after start
// one item at a time; results strobed for one cycle by done_o, never stalled;
// reset empties the queue at once; the heap RAM itself is not cleared
module binary_max_heap_queue #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  bmhq_pkg::req_t req_i,
  output logic           done_o,
  output bmhq_pkg::rsp_t rsp_o
);
  import bmhq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bmhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (req_i.command),
    .stat_i    (dp_stat),
    .busy_o    (busy_o),
    .cmd_o     (dp_cmd)
  );

  bmhq_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

@@ tb/sv/tb_binary_max_heap_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Self-checking testbench for the binary max-heap priority queue. A short
// directed sequence covers key extremes, ties and delete on empty. A fill
// sequence drives the queue to full, checks insert-when-full rejects and then
// deletes part of it. Random insert/delete mixes follow, run with varying
// sender gaps. Every accepted command is applied to a local heap that
// predicts the response, and each done beat is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  binary_max_heap_queue #(
    .DEPTH   (HEAP_DEPTH),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  logic [KEY_W-1:0] model_heap [1:HEAP_DEPTH];
  int unsigned      model_count = 0;
  int unsigned      peak_count = 0;
  rsp_t             owed_rsp_q [$];

  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned inserts_sent = 0;
  int unsigned deletes_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned empty_rejects = 0;
  int unsigned full_rejects = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic rsp_t next_heap_response(req_t r);
    rsp_t             res;
    int unsigned      pos;
    int unsigned      up;
    int unsigned      c;
    logic [KEY_W-1:0] moving;
    res.max_key = '0;
    res.status  = ST_OK;
    if (r.command == CMD_INSERT) begin
      if (model_count >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_count++;
        pos = model_count;
        while (pos > 1) begin
          up = pos / 2;
          if (model_heap[up] >= r.key) break;
          model_heap[pos] = model_heap[up];
          pos = up;
        end
        model_heap[pos] = r.key;
      end
    end else begin
      if (model_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.max_key = model_heap[1];
        moving = model_heap[model_count];
        model_count--;
        pos = 1;
        while (2 * pos <= model_count) begin
          c = 2 * pos;
          if (c + 1 <= model_count && model_heap[c] < model_heap[c+1]) c++;
          if (moving >= model_heap[c]) break;
          model_heap[pos] = model_heap[c];
          pos = c;
        end
        model_heap[pos] = moving;
      end
    end
    if (model_count > peak_count) peak_count = model_count;
    res.count = model_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom();
      // crowded small keys force ties in both sift directions
      5, 6: return KEY_W'($urandom_range(7));
      7: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h0001_0000;
        endcase
      end
      default: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(15));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_beat(cmd_e cmd, logic [KEY_W-1:0] k);
    req_t        r;
    int unsigned idle;
    r.command = cmd;
    r.key     = k;
    idle = 0;
    while (idle < 100 && $urandom_range(99) < idle_pct) idle++;
    if (idle != 0) begin
      start_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    if (cmd == CMD_INSERT) inserts_sent++;
    else deletes_sent++;
    owed_rsp_q.push_back(next_heap_response(r));
  endtask

  task automatic hold_until_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (owed_rsp_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (owed_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat max_key %h status %0d count %0d",
                                  rsp_o.max_key, rsp_o.status, rsp_o.count));
      end else begin
        want = owed_rsp_q.pop_front();
        beats_checked++;
        if (want.status == ST_EMPTY) empty_rejects++;
        if (want.status == ST_FULL) full_rejects++;
        if (rsp_o.max_key !== want.max_key)
          report_mismatch($sformatf("beat %0d max_key expected %h got %h",
                                    beats_checked, want.max_key, rsp_o.max_key));
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("beat %0d status expected %0d got %0d",
                                    beats_checked, want.status, rsp_o.status));
        if (rsp_o.count !== want.count)
          report_mismatch($sformatf("beat %0d count expected %0d got %0d",
                                    beats_checked, want.count, rsp_o.count));
      end
    end
  end

  task automatic test_directed();
    idle_pct = 0;
    send_beat(CMD_DELETE, '1);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_INSERT, '1);
    send_beat(CMD_INSERT, '1);
    send_beat(CMD_INSERT, 32'h0001_0000);
    send_beat(CMD_INSERT, 32'h8000_0000);
    send_beat(CMD_INSERT, 32'h0000_0001);
    send_beat(CMD_INSERT, 32'h7FFF_FFFF);
    send_beat(CMD_INSERT, '0);
    for (int i = 0; i < 8; i++) send_beat(CMD_DELETE, (i % 2 == 0) ? '1 : '0);
    send_beat(CMD_DELETE, '0);
    // equal keys stop the sift
    send_beat(CMD_INSERT, 32'd5);
    send_beat(CMD_INSERT, 32'd5);
    send_beat(CMD_INSERT, 32'd3);
    send_beat(CMD_INSERT, 32'd5);
    send_beat(CMD_DELETE, 32'h5555_5555);
    send_beat(CMD_DELETE, 32'hAAAA_AAAA);
    hold_until_drained();
  endtask

  task automatic test_fill_to_full();
    idle_pct = 0;
    while (model_count < HEAP_DEPTH) send_beat(CMD_INSERT, pick_key());
    send_beat(CMD_INSERT, '1);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_DELETE, $urandom());
    send_beat(CMD_INSERT, pick_key());
    send_beat(CMD_INSERT, pick_key());
    while (model_count > HEAP_DEPTH - 64) send_beat(CMD_DELETE, $urandom());
    hold_until_drained();
  endtask

  task automatic test_random_mix();
    int unsigned phase_idle [3] = '{0, 87, 22};
    int unsigned ins_pct;
    ins_pct = 50;
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < 145; i++) begin
        if (i % 64 == 0) begin
          case ($urandom_range(3))
            0: ins_pct = 25;
            1: ins_pct = 50;
            2: ins_pct = 70;
            default: ins_pct = 90;
          endcase
        end
        if ($urandom_range(49) == 0) hold_until_drained();
        if ($urandom_range(99) < ins_pct) send_beat(CMD_INSERT, pick_key());
        else send_beat(CMD_DELETE, $urandom());
      end
      hold_until_drained();
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_full();
    test_random_mix();

    start_i <= 1'b0;
    waited = 0;
    while (owed_rsp_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (owed_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", owed_rsp_q.size()));

    $display("covered %0d inserts and %0d deletes, %0d beats checked",
             inserts_sent, deletes_sent, beats_checked);
    $display("%0d empty rejects, %0d full rejects, peak occupancy %0d of %0d",
             empty_rejects, full_rejects, peak_count, HEAP_DEPTH);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
